### design/imtwc_pkg.sv
// ----------------------------------------------------------------------------
// IMU motion trigger window capture - shared package
// Widths, constants and types used by the capture core and its units.
// ----------------------------------------------------------------------------
package imtwc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COR_W       = 18;
   localparam int OFFSET_W    = 17;
   localparam int SUM_W       = 20;
   localparam int COUNT_W     = 5;
   localparam int FILL_W      = 7;
   localparam int THRESHOLD_W = 15;
   localparam int NORM_W      = 16;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 15'd30;

   // (v + 2000) / 4000 scaled to UQ0.16
   localparam int                 NORM_BIAS  = 2000;
   localparam int                 NORM_SPAN  = 4000;
   localparam int                 NORM_SHIFT = 30;
   localparam logic [23:0]        NORM_MUL   = 24'd8589935;
   localparam logic [22:0]        NORM_ROUND = 23'd62;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] x;
      logic signed [OFFSET_W-1:0] y;
      logic signed [OFFSET_W-1:0] z;
   } imtwc_offset_type;

endpackage

### design/imtwc_norm.sv
// ----------------------------------------------------------------------------
// IMU motion trigger window capture - axis normaliser
// Maps a signed axis value to round((v + 2000) / 4000) in UQ0.16, saturated.
// ----------------------------------------------------------------------------
module imtwc_norm (
   input  logic signed [imtwc_pkg::COR_W-1:0]  value,
   output logic        [imtwc_pkg::NORM_W-1:0] norm
);

   logic signed [imtwc_pkg::COR_W:0] biased;
   logic        [22:0]               scaled;
   logic        [46:0]               prod;

   always_comb begin
      biased = (imtwc_pkg::COR_W + 1)'(value) + (imtwc_pkg::COR_W + 1)'(imtwc_pkg::NORM_BIAS);
      // (4096 n + 125) / 250 == floor((2048 n + 62) / 125)
      scaled = {biased[11:0], 11'b0} + imtwc_pkg::NORM_ROUND;
      prod   = 47'(scaled) * 47'(imtwc_pkg::NORM_MUL);
      if (biased <= 0) begin
         norm = '0;
      end else if (biased >= (imtwc_pkg::COR_W + 1)'(imtwc_pkg::NORM_SPAN)) begin
         norm = '1;
      end else begin
         norm = prod[imtwc_pkg::NORM_SHIFT +: imtwc_pkg::NORM_W];
      end
   end

endmodule

### design/imtwc_calib.sv
// ----------------------------------------------------------------------------
// IMU motion trigger window capture - offset calibration
// Counts warm-up items, sums raw acceleration over the calibration span and
// keeps the per-axis offset (sum / CAL_LEN, truncated toward zero).
// ----------------------------------------------------------------------------
module imtwc_calib #(
   parameter int CAL_START = 10,
   parameter int CAL_LEN   = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     take,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]    accel_x,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]    accel_y,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]    accel_z,
   output logic                                     cal_done,
   output imtwc_pkg::imtwc_offset_type              offset
);

   localparam int          CAL_END   = CAL_START + CAL_LEN;
   localparam int          DIV_SHIFT = 23;
   localparam logic [23:0] DIV_MUL   = 24'((2**DIV_SHIFT + CAL_LEN - 1) / CAL_LEN);

   logic [imtwc_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic signed [imtwc_pkg::SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [imtwc_pkg::SUM_W-1:0] sum_y_ff, sum_y_in;
   logic signed [imtwc_pkg::SUM_W-1:0] sum_z_ff, sum_z_in;
   imtwc_pkg::imtwc_offset_type       offset_ff, offset_in;
   logic                              in_range;

   function automatic logic signed [imtwc_pkg::OFFSET_W-1:0] div_sum(
      input logic signed [imtwc_pkg::SUM_W-1:0] sum
   );
      logic [imtwc_pkg::SUM_W-1:0]    mag;
      logic [43:0]                    prod;
      logic [imtwc_pkg::OFFSET_W-1:0] quo;
      mag  = sum[imtwc_pkg::SUM_W-1] ? imtwc_pkg::SUM_W'(-sum) : imtwc_pkg::SUM_W'(sum);
      prod = 44'(mag) * 44'(DIV_MUL);
      quo  = prod[DIV_SHIFT +: imtwc_pkg::OFFSET_W];
      div_sum = sum[imtwc_pkg::SUM_W-1] ? -$signed(quo) : $signed(quo);
   endfunction

   always_comb begin
      in_range  = (count_ff >= imtwc_pkg::COUNT_W'(CAL_START)) &&
                  (count_ff <  imtwc_pkg::COUNT_W'(CAL_END));
      cal_done  = count_ff >= imtwc_pkg::COUNT_W'(CAL_END);
      count_in  = count_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_z_in  = sum_z_ff;
      offset_in = offset_ff;
      if (take && !cal_done) begin
         count_in = count_ff + 1'b1;
      end
      if (take && in_range) begin
         sum_x_in    = sum_x_ff + imtwc_pkg::SUM_W'(accel_x);
         sum_y_in    = sum_y_ff + imtwc_pkg::SUM_W'(accel_y);
         sum_z_in    = sum_z_ff + imtwc_pkg::SUM_W'(accel_z);
         offset_in.x = div_sum(sum_x_in);
         offset_in.y = div_sum(sum_y_in);
         offset_in.z = div_sum(sum_z_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_z_ff  <= '0;
         offset_ff <= '0;
      end else begin
         count_ff  <= count_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_z_ff  <= sum_z_in;
         offset_ff <= offset_in;
      end
   end

   assign offset = offset_ff;

endmodule

### design/imu_motion_trigger_window_capture_core.sv
// ----------------------------------------------------------------------------
// IMU motion trigger window capture - top level
// Offset calibration, motion trigger and windowed capture of normalised items.
// ----------------------------------------------------------------------------
// One six-axis item is taken per clock cycle; a captured item reaches the rsp
// channel through the input register, then the result register, and the
// throughput stays at one item per cycle while rsp_ready is
// high. The calibration items (from CAL_START to CAL_START+CAL_LEN-1 after
// reset) build the per-axis acceleration offset, which is divided by CAL_LEN
// with a reciprocal multiply as each of those items is taken; no item before
// the end of calibration produces a result. Afterwards an item whose
// corrected acceleration sum reaches ten times csr_accel_threshold opens a
// window of WINDOW_LEN items, each delivered with all six axes mapped to
// UQ0.16 by six parallel multipliers in the stage ahead of the result register.
// Items outside a window are consumed without a result.
module imu_motion_trigger_window_capture_core #(
   parameter int WINDOW_LEN = 72,
   parameter int CAL_START  = 10,
   parameter int CAL_LEN    = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [imtwc_pkg::THRESHOLD_W-1:0]      csr_accel_threshold,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]  req_gyro_x,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]  req_gyro_y,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]  req_gyro_z,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]  req_accel_x,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]  req_accel_y,
   input  logic signed [imtwc_pkg::SAMPLE_W-1:0]  req_accel_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [imtwc_pkg::NORM_W-1:0]           rsp_norm_gyro_x,
   output logic [imtwc_pkg::NORM_W-1:0]           rsp_norm_gyro_y,
   output logic [imtwc_pkg::NORM_W-1:0]           rsp_norm_gyro_z,
   output logic [imtwc_pkg::NORM_W-1:0]           rsp_norm_accel_x,
   output logic [imtwc_pkg::NORM_W-1:0]           rsp_norm_accel_y,
   output logic [imtwc_pkg::NORM_W-1:0]           rsp_norm_accel_z,
   output logic [imtwc_pkg::FILL_W-1:0]           rsp_sample_index,
   output logic                                   rsp_window_last
);

   localparam int COR_W = imtwc_pkg::COR_W;
   localparam int ACC_W = COR_W + 3;

   logic [imtwc_pkg::THRESHOLD_W-1:0] threshold_ff, threshold_in;

   logic                                  req_take;
   logic                                  cal_done;
   imtwc_pkg::imtwc_offset_type           offset;

   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s1_cal_done_ff;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] s1_gyro_x_ff, s1_gyro_y_ff, s1_gyro_z_ff;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] s1_accel_x_ff, s1_accel_y_ff, s1_accel_z_ff;

   logic                                  out_free;
   logic                                  s1_advance;
   logic signed [COR_W-1:0]               gyro_x_ext, gyro_y_ext, gyro_z_ext;
   logic signed [COR_W-1:0]               cor_x, cor_y, cor_z;
   logic signed [ACC_W-1:0]               accel_sum;
   logic [ACC_W-2:0]                      threshold_x10;
   logic                                  trigger;
   logic                                  emit;
   logic                                  last;

   logic [imtwc_pkg::FILL_W-1:0]          fill_ff, fill_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   logic [imtwc_pkg::NORM_W-1:0]          norm_gx, norm_gy, norm_gz;
   logic [imtwc_pkg::NORM_W-1:0]          norm_ax, norm_ay, norm_az;
   logic [imtwc_pkg::NORM_W-1:0]          norm_gx_ff, norm_gy_ff, norm_gz_ff;
   logic [imtwc_pkg::NORM_W-1:0]          norm_ax_ff, norm_ay_ff, norm_az_ff;
   logic [imtwc_pkg::FILL_W-1:0]          index_ff;
   logic                                  last_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_valid && csr_ready) begin
         threshold_in = csr_accel_threshold;
      end
   end

   // handshake and stage control
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      s1_advance  = s1_valid_ff && out_free;
      req_ready   = !s1_valid_ff || out_free;
      req_take    = req_valid && req_ready;
      s1_valid_in = req_take || (s1_valid_ff && !out_free);
   end

   imtwc_calib #(
      .CAL_START (CAL_START),
      .CAL_LEN   (CAL_LEN)
   ) u_calib (
      .clock    (clock),
      .reset    (reset),
      .take     (req_take),
      .accel_x  (req_accel_x),
      .accel_y  (req_accel_y),
      .accel_z  (req_accel_z),
      .cal_done (cal_done),
      .offset   (offset)
   );

   // correction and trigger
   always_comb begin
      gyro_x_ext    = COR_W'(s1_gyro_x_ff);
      gyro_y_ext    = COR_W'(s1_gyro_y_ff);
      gyro_z_ext    = COR_W'(s1_gyro_z_ff);
      cor_x         = COR_W'(s1_accel_x_ff) - COR_W'(offset.x);
      cor_y         = COR_W'(s1_accel_y_ff) - COR_W'(offset.y);
      cor_z         = COR_W'(s1_accel_z_ff) - COR_W'(offset.z);
      accel_sum     = ACC_W'(cor_x) + ACC_W'(cor_y) + ACC_W'(cor_z);
      threshold_x10 = (ACC_W - 1)'({threshold_ff, 3'b000}) +
                      (ACC_W - 1)'({threshold_ff, 1'b0});
      trigger       = accel_sum >= $signed({1'b0, threshold_x10});
      emit          = s1_advance && s1_cal_done_ff && (trigger || (fill_ff != '0));
      last          = fill_ff == imtwc_pkg::FILL_W'(WINDOW_LEN - 1);
      fill_in       = fill_ff;
      if (emit) begin
         fill_in = last ? '0 : fill_ff + 1'b1;
      end
      rsp_valid_in  = out_free ? emit : rsp_valid_ff;
   end

   imtwc_norm u_norm_gx (.value(gyro_x_ext), .norm(norm_gx));
   imtwc_norm u_norm_gy (.value(gyro_y_ext), .norm(norm_gy));
   imtwc_norm u_norm_gz (.value(gyro_z_ext), .norm(norm_gz));
   imtwc_norm u_norm_ax (.value(cor_x),      .norm(norm_ax));
   imtwc_norm u_norm_ay (.value(cor_y),      .norm(norm_ay));
   imtwc_norm u_norm_az (.value(cor_z),      .norm(norm_az));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= imtwc_pkg::THRESHOLD_RESET;
         s1_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         s1_valid_ff  <= s1_valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cal_done_ff <= cal_done;
         s1_gyro_x_ff   <= req_gyro_x;
         s1_gyro_y_ff   <= req_gyro_y;
         s1_gyro_z_ff   <= req_gyro_z;
         s1_accel_x_ff  <= req_accel_x;
         s1_accel_y_ff  <= req_accel_y;
         s1_accel_z_ff  <= req_accel_z;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit) begin
         norm_gx_ff <= norm_gx;
         norm_gy_ff <= norm_gy;
         norm_gz_ff <= norm_gz;
         norm_ax_ff <= norm_ax;
         norm_ay_ff <= norm_ay;
         norm_az_ff <= norm_az;
         index_ff   <= fill_ff;
         last_ff    <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_norm_gyro_x  = norm_gx_ff;
   assign rsp_norm_gyro_y  = norm_gy_ff;
   assign rsp_norm_gyro_z  = norm_gz_ff;
   assign rsp_norm_accel_x = norm_ax_ff;
   assign rsp_norm_accel_y = norm_ay_ff;
   assign rsp_norm_accel_z = norm_az_ff;
   assign rsp_sample_index = index_ff;
   assign rsp_window_last  = last_ff;

   // checks
   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff < imtwc_pkg::FILL_W'(WINDOW_LEN))
      else $error("window fill beyond window length");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> index_ff == imtwc_pkg::FILL_W'(WINDOW_LEN - 1))
      else $error("window closed at wrong index");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> fill_ff == '0)
      else $error("window did not close");

   a_no_warmup_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_cal_done_ff |=> fill_ff == $past(fill_ff))
      else $error("warm-up item touched the window");

endmodule

### test/tb_imu_motion_trigger_window_capture_core.sv
// ----------------------------------------------------------------------------
// IMU motion trigger window capture - core testbench
// Drives six-axis items through the capture core and checks every captured
// item. A scoreboard class tracks warm-up, offset calibration, the trigger
// threshold and the window fill. It predicts each normalised result and
// compares it field by field. Both channels idle and stall at random. The
// threshold is rewritten between phases once the core has drained.
// ----------------------------------------------------------------------------
module tb_imu_motion_trigger_window_capture_core;

   localparam int WINDOW_LEN     = 72;
   localparam int CAL_START      = 10;
   localparam int CAL_LEN        = 10;
   localparam int CAL_END        = CAL_START + CAL_LEN;
   localparam int DRAIN_CYCLES   = 4;
   localparam int LONG_HOLD      = 120;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 150;
   localparam int SAMPLE_MAX     = 32767;
   localparam int SAMPLE_MIN     = -32768;
   localparam int THRESHOLD_MAX  = 32767;

   typedef struct packed {
      logic signed [imtwc_pkg::SAMPLE_W-1:0] gyro_x;
      logic signed [imtwc_pkg::SAMPLE_W-1:0] gyro_y;
      logic signed [imtwc_pkg::SAMPLE_W-1:0] gyro_z;
      logic signed [imtwc_pkg::SAMPLE_W-1:0] accel_x;
      logic signed [imtwc_pkg::SAMPLE_W-1:0] accel_y;
      logic signed [imtwc_pkg::SAMPLE_W-1:0] accel_z;
   } imu_sample_type;

   typedef struct packed {
      logic [imtwc_pkg::NORM_W-1:0] norm_gyro_x;
      logic [imtwc_pkg::NORM_W-1:0] norm_gyro_y;
      logic [imtwc_pkg::NORM_W-1:0] norm_gyro_z;
      logic [imtwc_pkg::NORM_W-1:0] norm_accel_x;
      logic [imtwc_pkg::NORM_W-1:0] norm_accel_y;
      logic [imtwc_pkg::NORM_W-1:0] norm_accel_z;
      logic [imtwc_pkg::FILL_W-1:0] sample_index;
      logic                         window_last;
   } capture_item_type;

   class capture_tracker;
      logic [imtwc_pkg::THRESHOLD_W-1:0] threshold;
      int unsigned                       warmup_count;
      int                                offset_sum_x;
      int                                offset_sum_y;
      int                                offset_sum_z;
      int unsigned                       window_fill;
      int unsigned                       errors;
      capture_item_type                  pending_captures[$];

      function new();
         threshold    = imtwc_pkg::THRESHOLD_RESET;
         warmup_count = 0;
         offset_sum_x = 0;
         offset_sum_y = 0;
         offset_sum_z = 0;
         window_fill  = 0;
         errors       = 0;
      endfunction

      function logic [imtwc_pkg::NORM_W-1:0] uq16_norm(int v);
         longint n;
         longint q;
         n = longint'(v) + imtwc_pkg::NORM_BIAS;
         if (n <= 0) begin
            return '0;
         end
         q = (n * 65536 + imtwc_pkg::NORM_BIAS) / imtwc_pkg::NORM_SPAN;
         if (q > 65535) begin
            q = 65535;
         end
         return q[imtwc_pkg::NORM_W-1:0];
      endfunction

      function void take_sample(imu_sample_type s);
         int               ax;
         int               ay;
         int               az;
         bit               armed;
         capture_item_type c;
         ax = s.accel_x;
         ay = s.accel_y;
         az = s.accel_z;
         if (warmup_count >= CAL_START && warmup_count < CAL_END) begin
            offset_sum_x += ax;
            offset_sum_y += ay;
            offset_sum_z += az;
         end
         ax -= offset_sum_x / CAL_LEN;
         ay -= offset_sum_y / CAL_LEN;
         az -= offset_sum_z / CAL_LEN;
         armed = (warmup_count >= CAL_END);
         if (!armed) begin
            warmup_count++;
            return;
         end
         if (!(ax + ay + az >= 10 * int'(threshold) || window_fill != 0)) begin
            return;
         end
         c.sample_index = window_fill[imtwc_pkg::FILL_W-1:0];
         window_fill++;
         c.window_last = (window_fill >= WINDOW_LEN);
         if (c.window_last) begin
            window_fill = 0;
         end
         c.norm_gyro_x  = uq16_norm(s.gyro_x);
         c.norm_gyro_y  = uq16_norm(s.gyro_y);
         c.norm_gyro_z  = uq16_norm(s.gyro_z);
         c.norm_accel_x = uq16_norm(ax);
         c.norm_accel_y = uq16_norm(ay);
         c.norm_accel_z = uq16_norm(az);
         pending_captures.push_back(c);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t %s expected %0d actual %0d", $time, field, want, got);
            end
         end
      endfunction

      function void match_capture(capture_item_type got);
         capture_item_type want;
         if (pending_captures.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t unexpected item expected none actual index %0d",
                        $time, got.sample_index);
            end
            return;
         end
         want = pending_captures.pop_front();
         compare_field("norm_gyro_x", want.norm_gyro_x, got.norm_gyro_x);
         compare_field("norm_gyro_y", want.norm_gyro_y, got.norm_gyro_y);
         compare_field("norm_gyro_z", want.norm_gyro_z, got.norm_gyro_z);
         compare_field("norm_accel_x", want.norm_accel_x, got.norm_accel_x);
         compare_field("norm_accel_y", want.norm_accel_y, got.norm_accel_y);
         compare_field("norm_accel_z", want.norm_accel_z, got.norm_accel_z);
         compare_field("sample_index", want.sample_index, got.sample_index);
         compare_field("window_last", want.window_last, got.window_last);
      endfunction
   endclass

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [imtwc_pkg::THRESHOLD_W-1:0]     csr_accel_threshold = '0;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] req_gyro_x = '0;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] req_gyro_y = '0;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] req_gyro_z = '0;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] req_accel_x = '0;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] req_accel_y = '0;
   logic signed [imtwc_pkg::SAMPLE_W-1:0] req_accel_z = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [imtwc_pkg::NORM_W-1:0]          rsp_norm_gyro_x;
   logic [imtwc_pkg::NORM_W-1:0]          rsp_norm_gyro_y;
   logic [imtwc_pkg::NORM_W-1:0]          rsp_norm_gyro_z;
   logic [imtwc_pkg::NORM_W-1:0]          rsp_norm_accel_x;
   logic [imtwc_pkg::NORM_W-1:0]          rsp_norm_accel_y;
   logic [imtwc_pkg::NORM_W-1:0]          rsp_norm_accel_z;
   logic [imtwc_pkg::FILL_W-1:0]          rsp_sample_index;
   logic                                  rsp_window_last;

   capture_tracker sb = new();

   bit sender_burst  = 1'b0;
   bit long_hold_req = 1'b0;
   int cur_threshold = imtwc_pkg::THRESHOLD_RESET;
   int cal_off_x     = 0;
   int cal_off_y     = 0;
   int cal_off_z     = 0;

   imu_motion_trigger_window_capture_core #(
      .WINDOW_LEN (WINDOW_LEN),
      .CAL_START  (CAL_START),
      .CAL_LEN    (CAL_LEN)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_accel_threshold (csr_accel_threshold),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_gyro_x          (req_gyro_x),
      .req_gyro_y          (req_gyro_y),
      .req_gyro_z          (req_gyro_z),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_norm_gyro_x     (rsp_norm_gyro_x),
      .rsp_norm_gyro_y     (rsp_norm_gyro_y),
      .rsp_norm_gyro_z     (rsp_norm_gyro_z),
      .rsp_norm_accel_x    (rsp_norm_accel_x),
      .rsp_norm_accel_y    (rsp_norm_accel_y),
      .rsp_norm_accel_z    (rsp_norm_accel_z),
      .rsp_sample_index    (rsp_sample_index),
      .rsp_window_last     (rsp_window_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.match_capture({rsp_norm_gyro_x, rsp_norm_gyro_y, rsp_norm_gyro_z,
                              rsp_norm_accel_x, rsp_norm_accel_y, rsp_norm_accel_z,
                              rsp_sample_index, rsp_window_last});
         end
         if (req_valid && req_ready) begin
            sb.take_sample({req_gyro_x, req_gyro_y, req_gyro_z,
                            req_accel_x, req_accel_y, req_accel_z});
         end
         if (csr_valid && csr_ready) begin
            sb.threshold = csr_accel_threshold;
         end
      end
   end

   function automatic logic signed [imtwc_pkg::SAMPLE_W-1:0] clamp16(int v);
      if (v > SAMPLE_MAX) begin
         return imtwc_pkg::SAMPLE_W'(SAMPLE_MAX);
      end
      if (v < SAMPLE_MIN) begin
         return imtwc_pkg::SAMPLE_W'(SAMPLE_MIN);
      end
      return v[imtwc_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic imu_sample_type make_sample(int gx, int gy, int gz,
                                                  int ax, int ay, int az);
      imu_sample_type s;
      s.gyro_x  = clamp16(gx);
      s.gyro_y  = clamp16(gy);
      s.gyro_z  = clamp16(gz);
      s.accel_x = clamp16(ax);
      s.accel_y = clamp16(ay);
      s.accel_z = clamp16(az);
      return s;
   endfunction

   // mostly around the normalising span, some full scale, some on its edges
   function automatic int near_value(int centre);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return centre + int'($urandom_range(0, 5000)) - 2500;
      end else if (pick < 8) begin
         return int'($signed(16'($urandom())));
      end else if (pick == 8) begin
         return centre + ($urandom_range(0, 1) ? 2000 : -2000) + int'($urandom_range(0, 2)) - 1;
      end
      return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
   endfunction

   function automatic imu_sample_type random_sample();
      return make_sample(near_value(0), near_value(0), near_value(0),
                         near_value(cal_off_x), near_value(cal_off_y), near_value(cal_off_z));
   endfunction

   function automatic imu_sample_type trigger_sample();
      int share;
      share = cur_threshold * 10 / 3 + 1;
      return make_sample(near_value(0), near_value(0), near_value(0),
                         cal_off_x + share + int'($urandom_range(0, 800)),
                         cal_off_y + share + int'($urandom_range(0, 800)),
                         cal_off_z + share + int'($urandom_range(0, 800)));
   endfunction

   function automatic int pick_gap();
      int pick;
      if (sender_burst) begin
         return 0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return 0;
      end else if (pick < 9) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_sample(input imu_sample_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_gyro_x  <= s.gyro_x;
      req_gyro_y  <= s.gyro_y;
      req_gyro_z  <= s.gyro_z;
      req_accel_x <= s.accel_x;
      req_accel_y <= s.accel_y;
      req_accel_z <= s.accel_z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold the sender until every capture is out and the pipeline is empty
   task automatic drain_captures();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_captures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      drain_captures();
      csr_valid           <= 1'b1;
      csr_accel_threshold <= value[imtwc_pkg::THRESHOLD_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      cur_threshold = value;
   endtask

   task automatic run_phase(input int value, input int count, input bit hold_rsp);
      write_threshold(value);
      sender_burst = hold_rsp || ($urandom_range(0, 2) == 0);
      long_hold_req = hold_rsp;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            send_sample(trigger_sample());
         end else begin
            send_sample(random_sample());
         end
      end
   endtask

   initial begin
      int stall_left;
      int cycle_no;
      bit quiet;
      stall_left = 0;
      cycle_no   = 0;
      quiet      = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no % 64 == 0) begin
            quiet = ($urandom_range(0, 2) == 0);
         end
         if (long_hold_req && rsp_valid) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("imu_motion_trigger_window_capture_core: mismatch");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // warm-up ahead of calibration: full scale, well over the trigger, no item out
      send_sample(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                              SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
      send_sample(make_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                              SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      send_sample(make_sample(-2000, 2000, -1, SAMPLE_MAX, 20000, 20000));
      repeat (CAL_START - 4) send_sample(make_sample(near_value(0), near_value(0),
                                                     near_value(0), near_value(0),
                                                     near_value(0), near_value(0)));
      // calibration window, one extreme per axis
      send_sample(make_sample(near_value(0), near_value(0), near_value(0),
                              SAMPLE_MAX, SAMPLE_MIN, int'($urandom_range(0, 8000)) - 4000));
      send_sample(make_sample(near_value(0), near_value(0), near_value(0),
                              int'($urandom_range(0, 8000)) - 4000,
                              int'($urandom_range(0, 8000)) - 4000, SAMPLE_MAX));
      repeat (CAL_LEN - 2) send_sample(make_sample(near_value(0), near_value(0),
                                                   near_value(0),
                                                   int'($urandom_range(0, 8000)) - 4000,
                                                   int'($urandom_range(0, 8000)) - 4000,
                                                   int'($urandom_range(0, 8000)) - 4000));
      drain_captures();
      cal_off_x = sb.offset_sum_x / CAL_LEN;
      cal_off_y = sb.offset_sum_y / CAL_LEN;
      cal_off_z = sb.offset_sum_z / CAL_LEN;

      // one short of the trigger, then exactly on it, then normalising edges
      send_sample(make_sample(-2001, -2000, -1999,
                              cal_off_x + 10 * cur_threshold - 1, cal_off_y, cal_off_z));
      send_sample(make_sample(1999, 2000, 2001,
                              cal_off_x + 10 * cur_threshold, cal_off_y, cal_off_z));
      send_sample(make_sample(SAMPLE_MIN, SAMPLE_MAX, 0,
                              cal_off_x - 2000, cal_off_y - 1999, cal_off_z + 2000));
      send_sample(make_sample(0, 0, 0,
                              cal_off_x + 1999, cal_off_y - 2001, cal_off_z + 2001));
      send_sample(make_sample(-1, 1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
      send_sample(make_sample(SAMPLE_MAX, SAMPLE_MIN, 1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN));

      run_phase(0, 75, 1'b1);
      run_phase(THRESHOLD_MAX, 60, 1'b0);
      run_phase(1, 75, 1'b0);
      run_phase(150, 75, 1'b0);
      run_phase($urandom_range(0, 600), 75, 1'b0);
      run_phase(imtwc_pkg::THRESHOLD_RESET, 75, 1'b0);

      drain_captures();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("imu_motion_trigger_window_capture_core: match");
      end else begin
         $display("imu_motion_trigger_window_capture_core: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
design/imtwc_pkg.sv
design/imtwc_norm.sv
design/imtwc_calib.sv
design/imu_motion_trigger_window_capture_core.sv
test/tb_imu_motion_trigger_window_capture_core.sv
